// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the rotation-to-quaternion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hw/rtl/rmq_pkg.sv =====
// Shared constants and types for the rotation-to-quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int NUM_LANES      = 3;
  localparam int NUM_ELEMS      = 9;

  // Component taken from the square root.
  typedef enum logic [1:0] {
    DIAG_W,
    DIAG_X,
    DIAG_Y,
    DIAG_Z
  } diag_t;
endpackage

// ===== hw/rtl/rmq_in_if.sv =====
// Matrix input channel: valid/ready plus nine matrix elements.
`timescale 1ns / 1ps
interface rmq_in_if #(
  parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] elem0;
  logic signed [ELEM_WIDTH-1:0] elem1;
  logic signed [ELEM_WIDTH-1:0] elem2;
  logic signed [ELEM_WIDTH-1:0] elem3;
  logic signed [ELEM_WIDTH-1:0] elem4;
  logic signed [ELEM_WIDTH-1:0] elem5;
  logic signed [ELEM_WIDTH-1:0] elem6;
  logic signed [ELEM_WIDTH-1:0] elem7;
  logic signed [ELEM_WIDTH-1:0] elem8;

  modport source (output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6,
                  elem7, elem8, input ready);
  modport sink (input valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6,
                elem7, elem8, output ready);
endinterface

// ===== hw/rtl/rmq_out_if.sv =====
// Quaternion result channel: valid/ready plus four components.
`timescale 1ns / 1ps
interface rmq_out_if #(
  parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] quat_w;
  logic signed [ELEM_WIDTH-1:0] quat_x;
  logic signed [ELEM_WIDTH-1:0] quat_y;
  logic signed [ELEM_WIDTH-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hw/rtl/rotation_matrix_to_quaternion_core.sv =====
// Rotation matrix to unit quaternion (Shepperd's method), pipelined top level.
// Usage:
//   in_ch takes one 3x3 matrix per item: elem0..elem8, column-major, signed
//   Q2.14 at the default width. out_ch returns one item per matrix: quat_w,
//   quat_x, quat_y, quat_z, signed and saturated in the same format.
//   Both channels move an item when valid and ready are high at a clock edge.
// Throughput: one matrix per cycle, sustained while out_ch.ready stays high.
// Pipeline from accept to result valid: one front stage (trace, branch, root
//   argument), ELEM_WIDTH square-root stages (one root bit each),
//   2*ELEM_WIDTH-1 divider stages (one quotient bit each, three lanes in
//   parallel) and one saturation/output register.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so a receiver stall fills the pipe bubble by
// bubble before in_ch.ready falls; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is
// dropped and out_ch.valid is low in the next cycle.
// A zero root (degenerate matrix) saturates nonzero components by sign.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core #(
  parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  localparam int W    = ELEM_WIDTH;
  localparam int FRAC = W - 2;
  localparam int D    = 2 * W - 1;
  localparam int SB1  = NUM_LANES * (W + 1) + 2;
  localparam int SB2  = W + 2 + 2 * NUM_LANES;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // Front stage
  logic [NUM_ELEMS-1:0][W-1:0] elems;
  logic                        p_valid, p_ready;
  logic [2*W-1:0]              p_rad;
  logic [NUM_LANES-1:0][W:0]   p_num;
  diag_t                       p_diag;

  assign elems = {in_ch.elem8, in_ch.elem7, in_ch.elem6, in_ch.elem5, in_ch.elem4,
                  in_ch.elem3, in_ch.elem2, in_ch.elem1, in_ch.elem0};

  rmq_prep #(.W(W)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_elem   (elems),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_rad   (p_rad),
    .out_num   (p_num),
    .out_diag  (p_diag)
  );

  // Square root
  logic                      s_valid, s_ready;
  logic [W-1:0]              s_root;
  logic [SB1-1:0]            s_sb;
  logic [NUM_LANES-1:0][W:0] s_num;
  diag_t                     s_diag;

  rmq_sqrt_pipe #(.W(W), .SB(SB1)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_rad    (p_rad),
    .in_sb     ({p_num, p_diag}),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_sb    (s_sb)
  );

  assign s_num  = s_sb[SB1-1:2];
  assign s_diag = diag_t'(s_sb[1:0]);

  // Form rounded dividends: |n| * 2^FRAC + r, divisor 2r
  logic [NUM_LANES-1:0][D-1:0] dvd;
  logic [NUM_LANES-1:0]        s_neg, s_nz;

  always_comb begin
    logic [W:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      s_neg[l] = s_num[l][W];
      s_nz[l]  = |s_num[l];
      mag      = s_neg[l] ? (W+1)'(-s_num[l]) : s_num[l];
      dvd[l]   = {mag, {FRAC{1'b0}}} + D'(s_root);
    end
  end

  // Divide
  logic                        d_valid, d_ready;
  logic [NUM_LANES-1:0][D-1:0] d_quo;
  logic [SB2-1:0]              d_sb;
  logic [W-1:0]                d_root;
  diag_t                       d_diag;
  logic [NUM_LANES-1:0]        d_neg, d_nz;

  rmq_div_pipe #(.W(W), .SB(SB2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_den    ({s_root, 1'b0}),
    .in_dvd    (dvd),
    .in_sb     ({s_root, s_diag, s_neg, s_nz}),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quo   (d_quo),
    .out_sb    (d_sb)
  );

  assign d_root = d_sb[SB2-1 -: W];
  assign d_diag = diag_t'(d_sb[2*NUM_LANES+1 -: 2]);
  assign d_neg  = d_sb[2*NUM_LANES-1 -: NUM_LANES];
  assign d_nz   = d_sb[NUM_LANES-1:0];

  // Saturate quotients and the diagonal term
  logic signed [W-1:0] lane_q [NUM_LANES];
  logic [W:0]          rp1;
  logic signed [W-1:0] diag_q;
  logic signed [W-1:0] qw, qx, qy, qz;

  always_comb begin
    logic big;
    for (int l = 0; l < NUM_LANES; l++) begin
      big = |d_quo[l][D-1:W-1];
      if (!d_nz[l]) begin
        lane_q[l] = '0;
      end else if (d_root == '0) begin
        lane_q[l] = d_neg[l] ? VMIN : VMAX;
      end else if (d_neg[l]) begin
        lane_q[l] = big ? VMIN : -$signed(d_quo[l][W-1:0]);
      end else begin
        lane_q[l] = big ? VMAX : $signed(d_quo[l][W-1:0]);
      end
    end
  end

  assign rp1    = {1'b0, d_root} + (W+1)'(1);
  assign diag_q = rp1[W] ? VMAX : $signed(rp1[W:1]);

  // Place lanes into the components that are not diagonal
  always_comb begin
    unique case (d_diag)
      DIAG_W: begin
        qw = diag_q;    qx = lane_q[0]; qy = lane_q[1]; qz = lane_q[2];
      end
      DIAG_X: begin
        qw = lane_q[0]; qx = diag_q;    qy = lane_q[1]; qz = lane_q[2];
      end
      DIAG_Y: begin
        qw = lane_q[0]; qx = lane_q[1]; qy = diag_q;    qz = lane_q[2];
      end
      DIAG_Z: begin
        qw = lane_q[0]; qx = lane_q[1]; qy = lane_q[2]; qz = diag_q;
      end
      default: begin
        qw = '0;        qx = '0;        qy = '0;        qz = '0;
      end
    endcase
  end

  // Output register
  logic                out_valid_r;
  logic signed [W-1:0] qw_r, qx_r, qy_r, qz_r;

  assign d_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && d_valid) begin
      qw_r <= qw;
      qx_r <= qx;
      qy_r <= qy;
      qz_r <= qz;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.quat_w = qw_r;
  assign out_ch.quat_x = qx_r;
  assign out_ch.quat_y = qy_r;
  assign out_ch.quat_z = qz_r;

  // Reset empties the output stage
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid_r, "output valid after reset")
endmodule

// ===== hw/rtl/rmq_prep.sv =====
// Front stage: trace, branch choice, root argument and numerators.
`timescale 1ns / 1ps
module rmq_prep #(
  parameter int W = rmq_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rmq_pkg::NUM_ELEMS-1:0][W-1:0] in_elem,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*W-1:0]               out_rad,
  output logic [rmq_pkg::NUM_LANES-1:0][W:0] out_num,
  output rmq_pkg::diag_t               out_diag
);
  import rmq_pkg::*;

  localparam int FRAC = W - 2;

  logic signed [W+2:0] e [NUM_ELEMS];
  logic signed [W+2:0] one_c;
  logic signed [W+2:0] trace;
  logic signed [W+2:0] arg;
  logic [W:0]          arg_c;
  logic [W:0]          n57, n62, n13, p31, p62, p75;
  logic [NUM_LANES-1:0][W:0] num;
  diag_t               diag;

  logic                out_valid_r;
  logic [2*W-1:0]      rad_r;
  logic [NUM_LANES-1:0][W:0] num_r;
  diag_t               diag_r;

  // Sign-extend the elements for lossless sums
  always_comb begin
    for (int i = 0; i < NUM_ELEMS; i++) begin
      e[i] = (W+3)'($signed(in_elem[i]));
    end
  end

  assign one_c = {{4{1'b0}}, 1'b1, {FRAC{1'b0}}};
  assign trace = e[0] + e[4] + e[8];

  // Off-diagonal sums and differences
  assign n57 = (W+1)'(e[5] - e[7]);
  assign n62 = (W+1)'(e[6] - e[2]);
  assign n13 = (W+1)'(e[1] - e[3]);
  assign p31 = (W+1)'(e[3] + e[1]);
  assign p62 = (W+1)'(e[6] + e[2]);
  assign p75 = (W+1)'(e[7] + e[5]);

  // Pick branch by trace, then by largest diagonal
  always_comb begin
    priority if (trace > 0) begin
      diag = DIAG_W;
      arg  = trace + one_c;
      num  = {n13, n62, n57};
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      diag = DIAG_X;
      arg  = one_c + e[0] - e[4] - e[8];
      num  = {p62, p31, n57};
    end else if (e[4] > e[8]) begin
      diag = DIAG_Y;
      arg  = one_c + e[4] - e[0] - e[8];
      num  = {p75, p31, n62};
    end else begin
      diag = DIAG_Z;
      arg  = one_c + e[8] - e[0] - e[4];
      num  = {p75, p62, n13};
    end
  end

  // Clamp a negative argument to zero
  assign arg_c = arg[W+2] ? '0 : arg[W:0];

  assign in_ready = !out_valid_r || out_ready;

  // Hold the stage valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rad_r  <= {1'b0, arg_c, {FRAC{1'b0}}};
      num_r  <= num;
      diag_r <= diag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rad   = rad_r;
  assign out_num   = num_r;
  assign out_diag  = diag_r;
endmodule

// ===== hw/rtl/rmq_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmq_sqrt_pipe #(
  parameter int W  = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int SB = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2*W-1:0] in_rad,
  input  logic [SB-1:0]  in_sb,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   out_root,
  output logic [SB-1:0]  out_sb
);
  import rmq_pkg::*;

  localparam int N = W;

  logic           v_r    [N];
  logic [W+1:0]   rem_r  [N];
  logic [W-1:0]   root_r [N];
  logic [2*W-1:0] rad_r  [N];
  logic [SB-1:0]  sb_r   [N];
  logic [N:0]     adv;

  assign adv[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           prev_v;
    logic [W+1:0]   prev_rem;
    logic [W-1:0]   prev_root;
    logic [2*W-1:0] prev_rad;
    logic [SB-1:0]  prev_sb;
    logic [W+1:0]   sh;
    logic [W+1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_rad  = in_rad;
      assign prev_sb   = in_sb;
    end else begin : g_next
      assign prev_v    = v_r[k-1];
      assign prev_rem  = rem_r[k-1];
      assign prev_root = root_r[k-1];
      assign prev_rad  = rad_r[k-1];
      assign prev_sb   = sb_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign sh    = {prev_rem[W-1:0], prev_rad[2*W-1 -: 2]};
    assign trial = {prev_root, 2'b01};
    assign ge    = (sh >= trial);

    assign adv[k] = !v_r[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && prev_v) begin
        rem_r[k]  <= ge ? (sh - trial) : sh;
        root_r[k] <= {prev_root[W-2:0], ge};
        rad_r[k]  <= {prev_rad[2*W-3:0], 2'b00};
        sb_r[k]   <= prev_sb;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_sb    = sb_r[N-1];

  // Final remainder never exceeds twice the root, so root is the floor
  `ASSERT_CLK(a_sqrt_floor, clk, rst_n, v_r[N-1] |-> (rem_r[N-1] <= {1'b0, root_r[N-1], 1'b0}), "sqrt remainder exceeds 2*root")
endmodule

// ===== hw/rtl/rmq_div_pipe.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmq_div_pipe #(
  parameter int W  = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int SB = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [W:0]                           in_den,
  input  logic [rmq_pkg::NUM_LANES-1:0][2*W-2:0] in_dvd,
  input  logic [SB-1:0]                        in_sb,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rmq_pkg::NUM_LANES-1:0][2*W-2:0] out_quo,
  output logic [SB-1:0]                        out_sb
);
  import rmq_pkg::*;

  localparam int D = 2 * W - 1;
  localparam int N = D;

  logic                          v_r   [N];
  logic [W:0]                    den_r [N];
  logic [NUM_LANES-1:0][W:0]     rem_r [N];
  logic [NUM_LANES-1:0][D-1:0]   x_r   [N];
  logic [SB-1:0]                 sb_r  [N];
  logic [N:0]                    adv;

  assign adv[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        prev_v;
    logic [W:0]                  prev_den;
    logic [NUM_LANES-1:0][W:0]   prev_rem;
    logic [NUM_LANES-1:0][D-1:0] prev_x;
    logic [SB-1:0]               prev_sb;
    logic [NUM_LANES-1:0][W:0]   nrem;
    logic [NUM_LANES-1:0][D-1:0] nx;

    if (k == 0) begin : g_first
      assign prev_v   = in_valid;
      assign prev_den = in_den;
      assign prev_rem = '0;
      assign prev_x   = in_dvd;
      assign prev_sb  = in_sb;
    end else begin : g_next
      assign prev_v   = v_r[k-1];
      assign prev_den = den_r[k-1];
      assign prev_rem = rem_r[k-1];
      assign prev_x   = x_r[k-1];
      assign prev_sb  = sb_r[k-1];
    end

    // Shift in one dividend bit per lane and subtract where it fits
    always_comb begin
      logic [W+1:0] sh;
      logic [W+1:0] dv;
      logic         ge;
      for (int l = 0; l < NUM_LANES; l++) begin
        sh      = {prev_rem[l], prev_x[l][D-1]};
        dv      = {1'b0, prev_den};
        ge      = (sh >= dv);
        nrem[l] = ge ? (W+1)'(sh - dv) : sh[W:0];
        nx[l]   = {prev_x[l][D-2:0], ge};
      end
    end

    assign adv[k] = !v_r[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && prev_v) begin
        den_r[k] <= prev_den;
        rem_r[k] <= nrem;
        x_r[k]   <= nx;
        sb_r[k]  <= prev_sb;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[N-1];
  assign out_quo   = x_r[N-1];
  assign out_sb    = sb_r[N-1];

  // Remainder stays below a nonzero divisor in every lane
  `ASSERT_CLK(a_div_rem, clk, rst_n, (v_r[N-1] && den_r[N-1] != '0) |-> (rem_r[N-1][0] < den_r[N-1] && rem_r[N-1][1] < den_r[N-1] && rem_r[N-1][2] < den_r[N-1]), "divider remainder not below divisor")
endmodule

// ===== verif/rotation_matrix_to_quaternion_core_test.sv =====
// Randomized and directed check of the rotation-matrix-to-quaternion core.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_test;
  import rmq_pkg::*;

  localparam int EW = ELEM_WIDTH_DEF;
  localparam int FRAC = EW - 2;
  localparam longint QMAX = (64'sd1 <<< (EW - 1)) - 1;
  localparam longint QMIN = -(64'sd1 <<< (EW - 1));
  localparam int LATENCY = 3 * EW + 1;
  localparam int RANDOM_ITEMS = 1330;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct packed {
    elem_t w;
    elem_t x;
    elem_t y;
    elem_t z;
  } quat_t;

  // Expected quaternions in arrival order, with a mismatch count.
  class quat_scoreboard;
    quat_t pending[$];
    int errors = 0;

    static function longint isqrt(longint v);
      longint res;
      longint bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - res - bitv;
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    // Rounded, saturated fixed-point quotient n / den.
    static function elem_t scaled_div(longint n, longint den);
      longint mag;
      longint q;
      if (n == 0) return '0;
      if (den == 0) return (n < 0) ? elem_t'(QMIN) : elem_t'(QMAX);
      mag = (n < 0) ? -n : n;
      q = ((mag <<< FRAC) + (den >>> 1)) / den;
      if (n < 0) return (q > -QMIN) ? elem_t'(QMIN) : elem_t'(-q);
      return (q > QMAX) ? elem_t'(QMAX) : elem_t'(q);
    endfunction

    function void note_matrix(elem_t m[9]);
      longint e[9];
      longint one;
      longint tr;
      longint arg;
      longint r;
      longint den;
      longint dq;
      diag_t dg;
      quat_t q;
      one = 64'sd1 <<< FRAC;
      for (int i = 0; i < 9; i++) e[i] = m[i];
      tr = e[0] + e[4] + e[8];
      if (tr > 0) begin
        arg = tr + one; dg = DIAG_W;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
        arg = one + e[0] - e[4] - e[8]; dg = DIAG_X;
      end else if (e[4] > e[8]) begin
        arg = one + e[4] - e[0] - e[8]; dg = DIAG_Y;
      end else begin
        arg = one + e[8] - e[0] - e[4]; dg = DIAG_Z;
      end
      if (arg < 0) arg = 0;
      r = isqrt(arg <<< FRAC);
      den = r <<< 1;
      dq = (r + 1) >>> 1;
      if (dq > QMAX) dq = QMAX;
      case (dg)
        DIAG_W: begin
          q.w = elem_t'(dq);
          q.x = scaled_div(e[5] - e[7], den);
          q.y = scaled_div(e[6] - e[2], den);
          q.z = scaled_div(e[1] - e[3], den);
        end
        DIAG_X: begin
          q.x = elem_t'(dq);
          q.w = scaled_div(e[5] - e[7], den);
          q.y = scaled_div(e[3] + e[1], den);
          q.z = scaled_div(e[6] + e[2], den);
        end
        DIAG_Y: begin
          q.y = elem_t'(dq);
          q.w = scaled_div(e[6] - e[2], den);
          q.x = scaled_div(e[3] + e[1], den);
          q.z = scaled_div(e[7] + e[5], den);
        end
        default: begin
          q.z = elem_t'(dq);
          q.w = scaled_div(e[1] - e[3], den);
          q.x = scaled_div(e[6] + e[2], den);
          q.y = scaled_div(e[7] + e[5], den);
        end
      endcase
      pending.insert(pending.size(), q);
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time,
                 got.w, got.x, got.y, got.z);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.w !== want.w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stream_done = 1'b0;
  quat_scoreboard board;

  rmq_in_if #(.ELEM_WIDTH(EW)) in_ch ();
  rmq_out_if #(.ELEM_WIDTH(EW)) out_ch ();

  rotation_matrix_to_quaternion_core #(.ELEM_WIDTH(EW)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_core_test NOT OK");
      $finish;
    end
  end

  // Check each result item accepted at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_quat({out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z});
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stream_done || $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_matrix(elem_t m[9], int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.elem0 <= m[0]; in_ch.elem1 <= m[1]; in_ch.elem2 <= m[2];
    in_ch.elem3 <= m[3]; in_ch.elem4 <= m[4]; in_ch.elem5 <= m[5];
    in_ch.elem6 <= m[6]; in_ch.elem7 <= m[7]; in_ch.elem8 <= m[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_matrix(m);
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  // Build a near-rotation matrix with small random noise on each element.
  function automatic void near_rotation(ref elem_t m[9]);
    real a;
    real b;
    real c;
    real d;
    real n;
    real r[9];
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin a = 1.0; n = 1.0; end
    a = a / n; b = b / n; c = c / n; d = d / n;
    r[0] = 1 - 2 * (c * c + d * d); r[3] = 2 * (b * c - a * d); r[6] = 2 * (b * d + a * c);
    r[1] = 2 * (b * c + a * d); r[4] = 1 - 2 * (b * b + d * d); r[7] = 2 * (c * d - a * b);
    r[2] = 2 * (b * d - a * c); r[5] = 2 * (c * d + a * b); r[8] = 1 - 2 * (b * b + c * c);
    for (int i = 0; i < 9; i++)
      m[i] = elem_t'($rtoi(r[i] * (1 << FRAC)) + $signed($urandom_range(0, 8)) - 4);
  endfunction

  initial begin
    elem_t m[9];
    int k;
    board = new();
    in_ch.valid = 1'b0;
    in_ch.elem0 = '0; in_ch.elem1 = '0; in_ch.elem2 = '0;
    in_ch.elem3 = '0; in_ch.elem4 = '0; in_ch.elem5 = '0;
    in_ch.elem6 = '0; in_ch.elem7 = '0; in_ch.elem8 = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity, each diagonal branch, degenerate and extreme matrices.
    for (int t = 0; t < 14; t++) begin
      for (int i = 0; i < 9; i++) m[i] = '0;
      case (t)
        0: begin m[0] = 16384; m[4] = 16384; m[8] = 16384; end
        1: begin m[0] = 16384; m[4] = -16384; m[8] = -16384; end
        2: begin m[0] = -16384; m[4] = 16384; m[8] = -16384; end
        3: begin m[0] = -16384; m[4] = -16384; m[8] = 16384; end
        4: ;
        5: for (int i = 0; i < 9; i++) m[i] = elem_t'(QMAX);
        6: for (int i = 0; i < 9; i++) m[i] = elem_t'(QMIN);
        7: begin
          m[0] = elem_t'(QMIN); m[4] = elem_t'(QMIN); m[8] = elem_t'(QMIN);
          m[1] = 5; m[3] = -7; m[5] = elem_t'(QMAX); m[7] = elem_t'(QMIN);
        end
        8: begin m[0] = -16384; m[4] = -16384; m[8] = -16384; m[2] = 100; end
        9: begin
          m[0] = elem_t'(QMAX); m[4] = elem_t'(QMAX); m[8] = elem_t'(QMAX);
          m[5] = elem_t'(QMIN); m[7] = elem_t'(QMAX);
        end
        10: begin m[0] = 0; m[4] = 0; m[8] = 0; m[5] = 3; m[7] = -3; end
        11: begin m[1] = elem_t'(QMAX); m[3] = elem_t'(QMAX); m[0] = -1; m[4] = -1; end
        12: begin m[8] = -20000; m[0] = -20000; m[4] = -20000; m[6] = 9; end
        default: for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom);
      endcase
      send_matrix(m, draw_gap());
    end

    // Random: mostly near-rotations, the rest raw noise.
    hold_off = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom);
      end else begin
        near_rotation(m);
      end
      // Drain every result once midway.
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
      k = (n < 400 || $urandom_range(0, 4) == 0) ? 0 : draw_gap();
      send_matrix(m, k);
    end
    in_ch.valid <= 1'b0;
    stream_done = 1'b1;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("rotation_matrix_to_quaternion_core_test OK");
    end else begin
      $display("rotation_matrix_to_quaternion_core_test NOT OK");
    end
    $finish;
  end
endmodule
